@@ src/modular_multiplier_64_top_defines.svh @@
// Assertion macros for the modular multiplier checker.
// No dependencies; included by the checker file.
`ifndef MODULAR_MULTIPLIER_64_TOP_DEFINES_SVH
`define MODULAR_MULTIPLIER_64_TOP_DEFINES_SVH

// Check a consequence in the same cycle.
`define MM64_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mm64 check failed");

// Check a consequence in the following cycle.
`define MM64_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mm64 check failed");

`endif

@@ src/mm64_pkg.sv @@
// Shared constants for the modular multiplier: word size, mode and register codes,
// fixed prime and register reset values. No dependencies.
package mm64_pkg;

    localparam int WORD_BITS_DEF = 64;

    localparam logic [1:0] MODE_GENERAL = 2'd0;
    localparam logic [1:0] MODE_SOLINAS = 2'd1;
    localparam logic [1:0] MODE_MONT    = 2'd2;

    localparam logic [1:0] CFG_MODE      = 2'd0;
    localparam logic [1:0] CFG_GEN_MOD   = 2'd1;
    localparam logic [1:0] CFG_MONT_MOD  = 2'd2;
    localparam logic [1:0] CFG_MONT_NINV = 2'd3;

    localparam logic [63:0] SOLINAS_PRIME = 64'd18446744069414584321;
    localparam logic [63:0] GEN_MOD_RST   = 64'd18446744069414584321;
    localparam logic [63:0] MONT_MOD_RST  = 64'd9203387313508319233;
    localparam logic [63:0] MONT_NINV_RST = 64'd9203387313508319231;

endpackage

@@ src/mm64_mul.sv @@
// Two-stage full-width multiplier: half-word partial products, then their sum.
// Depends on mm64_pkg for the default word size.
module mm64_mul #(
    parameter int W = mm64_pkg::WORD_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [W-1:0]   i_a,
    input  logic [W-1:0]   i_b,
    output logic [2*W-1:0] o_p
);
    localparam int HL = W / 2;
    localparam int HH = W - HL;

    logic [2*HL-1:0]  r_ll;
    logic [HL+HH-1:0] r_lh;
    logic [HL+HH-1:0] r_hl;
    logic [2*HH-1:0]  r_hh;
    logic [2*W-1:0]   r_p;
    logic [2*W-1:0]   n_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= i_a[HL-1:0] * i_b[HL-1:0];
            r_lh <= i_a[HL-1:0] * i_b[W-1:HL];
            r_hl <= i_a[W-1:HL] * i_b[HL-1:0];
            r_hh <= i_a[W-1:HL] * i_b[W-1:HL];
            r_p  <= n_p;
        end
    end

    always_comb begin
        n_p = (2*W)'(r_ll) + ((2*W)'(r_lh) << HL) + ((2*W)'(r_hl) << HL)
            + ((2*W)'(r_hh) << (2*HL));
    end

    assign o_p = r_p;

endmodule

@@ src/mm64_div.sv @@
// Remainder pipeline: one restoring step per stage over the double-width dividend.
// Depends on mm64_pkg for the default word size.
module mm64_div #(
    parameter int W = mm64_pkg::WORD_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [2*W-1:0] i_dvd,
    input  logic [W-1:0]   i_mod,
    output logic [W-1:0]   o_rem
);
    localparam int D = 2 * W;

    logic [W-1:0]   r_rem [D];
    logic [2*W-1:0] r_dvd [D-1];

    for (genvar s = 0; s < D; s++) begin : g_step
        logic [W-1:0]   rem_in;
        logic [2*W-1:0] dvd_in;
        logic [W-1:0]   shifted;
        logic [W-1:0]   n_rem;

        if (s == 0) begin : g_first
            assign rem_in = '0;
            assign dvd_in = i_dvd;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign dvd_in = r_dvd[s-1];
        end

        always_comb begin
            shifted = {rem_in[W-2:0], dvd_in[2*W-1]};
            if (rem_in[W-1] || shifted >= i_mod) begin
                n_rem = shifted - i_mod;
            end else begin
                n_rem = shifted;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
            end
        end

        if (s < D - 1) begin : g_dvd
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_dvd[s] <= {dvd_in[2*W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_rem = r_rem[D-1];

endmodule

@@ src/modular_multiplier_64_top.sv @@
// Modular multiplier: general remainder, Solinas prime or Montgomery product.
// Accepts one item per cycle while the output is not stalled; built from the
// bit-per-stage remainder pipeline and the two-stage multipliers.
// Any output stall freezes the whole pipeline; nothing is lost or repeated.
// Synchronous active-low reset clears valid bits and restores register defaults.
// Depends on mm64_pkg, mm64_mul and mm64_div.
module modular_multiplier_64_top #(
    parameter int WORD_BITS = mm64_pkg::WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [WORD_BITS-1:0] i_operand_a,
    input  logic [WORD_BITS-1:0] i_operand_b,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [WORD_BITS-1:0] o_product,
    output logic                 o_operand_too_large,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [WORD_BITS-1:0] i_cfg_data
);
    import mm64_pkg::*;

    localparam int W   = WORD_BITS;
    localparam int L   = 2 * W + 2;
    localparam int DLY = 2 * W - 6;

    logic [1:0]   r_mode;
    logic [W-1:0] r_gen_mod;
    logic [W-2:0] r_mont_mod;
    logic [W-1:0] r_mont_ninv;

    logic         adv;
    logic [W-1:0] n_mont;
    logic         flag_in;
    logic         r_vld [L];
    logic         r_flg [L];

    logic [2*W-1:0] p_ab;
    logic [2*W-1:0] p_m;
    logic [2*W-1:0] p_mn;
    logic [W-1:0]   div_mod;
    logic [W-1:0]   div_rem;

    logic [W-1:0] r_tl [4];
    logic [W-1:0] r_th [4];
    logic [W:0]   sum_lo;
    logic [W-1:0] r_mr7;
    logic [W-1:0] r_mr8;
    logic [W-1:0] r_mdl [DLY];

    logic         r_out_vld;
    logic [W-1:0] r_product;
    logic         r_too_large;
    logic [W-1:0] n_product;
    logic         n_too_large;

    assign adv         = !r_out_vld || !i_stall;
    assign o_stall     = !adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_SOLINAS;
            r_gen_mod   <= GEN_MOD_RST[W-1:0];
            r_mont_mod  <= MONT_MOD_RST[W-2:0];
            r_mont_ninv <= MONT_NINV_RST[W-1:0];
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODE:      r_mode      <= i_cfg_data[1:0];
                CFG_GEN_MOD:   r_gen_mod   <= i_cfg_data;
                CFG_MONT_MOD:  r_mont_mod  <= i_cfg_data[W-2:0];
                CFG_MONT_NINV: r_mont_ninv <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign n_mont  = {1'b0, r_mont_mod};
    assign flag_in = (i_operand_a >= n_mont) || (i_operand_b >= n_mont);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < L; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < L; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_out_vld <= r_vld[L-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_flg[0] <= flag_in;
            for (int k = 1; k < L; k++) begin
                r_flg[k] <= r_flg[k-1];
            end
        end
    end

    mm64_mul #(.W(W)) u_mul_ab (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_a   (i_operand_a),
        .i_b   (i_operand_b),
        .o_p   (p_ab)
    );

    assign div_mod = (r_mode == MODE_SOLINAS) ? SOLINAS_PRIME[W-1:0] : r_gen_mod;

    mm64_div #(.W(W)) u_div (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_dvd (p_ab),
        .i_mod (div_mod),
        .o_rem (div_rem)
    );

    mm64_mul #(.W(W)) u_mul_m (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_a   (p_ab[W-1:0]),
        .i_b   (r_mont_ninv),
        .o_p   (p_m)
    );

    mm64_mul #(.W(W)) u_mul_mn (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_a   (p_m[W-1:0]),
        .i_b   (n_mont),
        .o_p   (p_mn)
    );

    assign sum_lo = {1'b0, r_tl[3]} + {1'b0, p_mn[W-1:0]};

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tl[0] <= p_ab[W-1:0];
            r_th[0] <= p_ab[2*W-1:W];
            for (int k = 1; k < 4; k++) begin
                r_tl[k] <= r_tl[k-1];
                r_th[k] <= r_th[k-1];
            end
            r_mr7 <= r_th[3] + p_mn[2*W-1:W] + W'(sum_lo[W]);
            r_mr8 <= (r_mr7 >= n_mont) ? (r_mr7 - n_mont) : r_mr7;
            r_mdl[0] <= r_mr8;
            for (int k = 1; k < DLY; k++) begin
                r_mdl[k] <= r_mdl[k-1];
            end
        end
    end

    always_comb begin
        n_too_large = 1'b0;
        case (r_mode)
            MODE_GENERAL: n_product = (r_gen_mod == '0) ? '0 : div_rem;
            MODE_SOLINAS: n_product = div_rem;
            MODE_MONT: begin
                n_product   = r_flg[L-1] ? '0 : r_mdl[DLY-1];
                n_too_large = r_flg[L-1];
            end
            default: n_product = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_product   <= n_product;
            r_too_large <= n_too_large;
        end
    end

    assign o_valid             = r_out_vld;
    assign o_product           = r_product;
    assign o_operand_too_large = r_too_large;

endmodule

@@ src/mm64_chk.sv @@
// Port-level checker for the modular multiplier, bound to the top level.
// Depends on modular_multiplier_64_top_defines.svh and mm64_pkg.
`include "modular_multiplier_64_top_defines.svh"

module mm64_chk #(
    parameter int W = mm64_pkg::WORD_BITS_DEF
) (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_stall,
    input logic         o_valid,
    input logic         i_stall,
    input logic [W-1:0] o_product,
    input logic         o_operand_too_large
);
    `MM64_ASSERT_NEXT(a_hold_out, o_valid && i_stall, o_valid && $stable(o_product))
    `MM64_ASSERT_NOW(a_flag_zero, o_valid && o_operand_too_large, o_product == '0)
    `MM64_ASSERT_NOW(a_stall_cause, o_stall, o_valid && i_stall)
endmodule

bind modular_multiplier_64_top mm64_chk #(.W(WORD_BITS)) u_chk (.*);
